// ----- hw/rtl/hlcd_pkg.sv -----
// Shared types and constants for the header/length/checksum frame parser.
package hlcd_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

  localparam logic [7:0] FIRST_HEADER_RESET  = 8'hAA;
  localparam logic [7:0] SECOND_HEADER_RESET = 8'h55;
  localparam logic [7:0] MAX_LENGTH_RESET    = 8'd250;
  localparam logic [7:0] FRAME_LIMIT         = 8'd250;

  // Position codes of the header, length, command and first data bytes within a frame.
  localparam logic [7:0] POS_SECOND_HEADER = 8'd1;
  localparam logic [7:0] POS_LENGTH_HIGH   = 8'd2;
  localparam logic [7:0] POS_LENGTH_LOW    = 8'd3;
  localparam logic [7:0] POS_COMMAND       = 8'd4;
  localparam logic [7:0] POS_FIRST_DATA    = 8'd5;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_END_GOOD = 2'd1;
  localparam logic [1:0] KIND_END_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
    logic       last;
  } result_t;

endpackage

// ----- hw/rtl/hlcd_parser.sv -----
// Frame parser state, configuration registers and per-byte result logic.
module hlcd_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [hlcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               accept,
  input  logic                               cmd,
  input  logic [7:0]                         rx_byte,
  output logic                               push,
  output hlcd_pkg::result_t                  result
);

  logic [7:0] first_header_byte;
  logic [7:0] second_header_byte;
  logic [7:0] max_data_length;

  logic       in_frame;
  logic [7:0] byte_position;
  logic [7:0] length_high;
  logic [7:0] frame_length_total;
  logic [7:0] command_byte;
  logic [7:0] running_sum;

  logic       in_frame_next;
  logic [7:0] byte_position_next;
  logic [7:0] length_high_next;
  logic [7:0] frame_length_total_next;
  logic [7:0] command_byte_next;
  logic [7:0] running_sum_next;

  logic [7:0] limit;
  logic [7:0] taken;
  logic       is_first_header;
  logic       emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header_byte  <= hlcd_pkg::FIRST_HEADER_RESET;
      second_header_byte <= hlcd_pkg::SECOND_HEADER_RESET;
      max_data_length    <= hlcd_pkg::MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        hlcd_pkg::CFG_FIRST_HEADER:  first_header_byte  <= cfg_data;
        hlcd_pkg::CFG_SECOND_HEADER: second_header_byte <= cfg_data;
        hlcd_pkg::CFG_MAX_LENGTH:    max_data_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limit = (max_data_length > hlcd_pkg::FRAME_LIMIT) ? hlcd_pkg::FRAME_LIMIT
                                                           : max_data_length;
  // Bytes past the command taken so far, counting the current one.
  assign taken = byte_position - 8'd4;
  assign is_first_header = (rx_byte == first_header_byte);

  always_comb begin
    in_frame_next           = in_frame;
    byte_position_next      = byte_position;
    length_high_next        = length_high;
    frame_length_total_next = frame_length_total;
    command_byte_next       = command_byte;
    running_sum_next        = running_sum;
    emit                    = 1'b0;

    result.kind           = hlcd_pkg::KIND_DATA;
    result.payload_byte   = rx_byte;
    result.payload_index  = byte_position - hlcd_pkg::POS_FIRST_DATA;
    result.frame_command  = command_byte;
    result.payload_length = frame_length_total - 8'd1;
    result.last           = 1'b0;

    if (cmd) begin
      in_frame_next           = 1'b0;
      byte_position_next      = '0;
      length_high_next        = '0;
      frame_length_total_next = '0;
      command_byte_next       = '0;
      running_sum_next        = '0;
    end else if (!in_frame) begin
      if (is_first_header) begin
        in_frame_next      = 1'b1;
        byte_position_next = hlcd_pkg::POS_SECOND_HEADER;
      end
    end else begin
      case (byte_position)
        hlcd_pkg::POS_SECOND_HEADER: begin
          if (rx_byte != second_header_byte) begin
            in_frame_next      = is_first_header;
            byte_position_next = is_first_header ? hlcd_pkg::POS_SECOND_HEADER : 8'd0;
          end else begin
            byte_position_next = hlcd_pkg::POS_LENGTH_HIGH;
          end
        end
        hlcd_pkg::POS_LENGTH_HIGH: begin
          length_high_next   = rx_byte;
          byte_position_next = hlcd_pkg::POS_LENGTH_LOW;
        end
        hlcd_pkg::POS_LENGTH_LOW: begin
          if (length_high != 8'd0 || rx_byte == 8'd0 || rx_byte > limit) begin
            in_frame_next      = is_first_header;
            byte_position_next = is_first_header ? hlcd_pkg::POS_SECOND_HEADER : 8'd0;
            length_high_next   = '0;
          end else begin
            frame_length_total_next = rx_byte;
            byte_position_next      = hlcd_pkg::POS_COMMAND;
          end
        end
        hlcd_pkg::POS_COMMAND: begin
          command_byte_next  = rx_byte;
          running_sum_next   = rx_byte;
          byte_position_next = hlcd_pkg::POS_FIRST_DATA;
        end
        default: begin
          emit = 1'b1;
          if (taken < frame_length_total) begin
            running_sum_next   = running_sum + rx_byte;
            byte_position_next = byte_position + 8'd1;
          end else begin
            // Checksum byte: close the frame and hunt again.
            result.kind             = (running_sum == rx_byte) ? hlcd_pkg::KIND_END_GOOD
                                                               : hlcd_pkg::KIND_END_BAD;
            result.payload_byte     = '0;
            result.payload_index    = '0;
            result.last             = 1'b1;
            in_frame_next           = 1'b0;
            byte_position_next      = '0;
            length_high_next        = '0;
            frame_length_total_next = '0;
            command_byte_next       = '0;
            running_sum_next        = '0;
          end
        end
      endcase
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame           <= 1'b0;
      byte_position      <= '0;
      length_high        <= '0;
      frame_length_total <= '0;
      command_byte       <= '0;
      running_sum        <= '0;
    end else if (accept) begin
      in_frame           <= in_frame_next;
      byte_position      <= byte_position_next;
      length_high        <= length_high_next;
      frame_length_total <= frame_length_total_next;
      command_byte       <= command_byte_next;
      running_sum        <= running_sum_next;
    end
  end

`ifndef ASSERT_OFF
  a_line_error_hunts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd |=> !in_frame && byte_position == 8'd0)
    else $error("line error did not return parser to hunting");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    push && result.last |->
      result.kind == hlcd_pkg::KIND_END_GOOD || result.kind == hlcd_pkg::KIND_END_BAD)
    else $error("frame end carries a data kind");

  a_position_in_bounds: assert property (@(posedge clk) disable iff (rst)
    in_frame && byte_position >= hlcd_pkg::POS_FIRST_DATA |->
      taken <= frame_length_total && frame_length_total != 8'd0)
    else $error("byte position ran past the frame length");

  a_hunting_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_position == 8'd0 && running_sum == 8'd0)
    else $error("hunting with stale frame state");
`endif

endmodule

// ----- hw/rtl/hlcd_skid.sv -----
// Two-entry output buffer that decouples the input stall from the output stall.
module hlcd_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hlcd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output hlcd_pkg::result_t out_data
);

  logic              skid_valid;
  hlcd_pkg::result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> out_valid && !skid_valid)
    else $error("skid entry not moved to output on transfer");
`endif

endmodule

// ----- hw/rtl/header_length_checksum_deframer_unit.sv -----
// Top level of the header/length/checksum frame parser.
//
// Received bytes enter on the input channel (in_valid, in_stall, cmd, rx_byte),
// one per transfer. cmd high marks a line error and forces the parser back to
// hunting for a header. Each data byte of a frame leaves as one result
// transfer as it arrives; the checksum byte produces a frame-end result with
// last high, the command, the data count and a good or bad kind. Header,
// length and command bytes produce no result.
// A result reaches out_valid in the cycle after its input transfer when the output
// register is free. One byte can be taken every cycle while in_stall is low: the
// per-byte update is a few compares and an 8-bit add from state to output register.
// A two-entry output buffer sits after the parser; in_stall rises only while
// its second entry is occupied, so a receiver stall costs no input cycle until
// two results are waiting. Results hold steady while out_stall is high.
// The configuration port writes the header bytes and the length limit; it is to
// be used only while the block is idle, which the block does not enforce. Reset
// clears frame state and buffer, restoring headers 0xAA, 0x55 and limit 250.
module header_length_checksum_deframer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [hlcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       kind,
  output logic [7:0]                       payload_byte,
  output logic [7:0]                       payload_index,
  output logic [7:0]                       frame_command,
  output logic [7:0]                       payload_length,
  output logic                             last
);

  logic              accept;
  logic              push;
  logic              full;
  hlcd_pkg::result_t push_data;
  hlcd_pkg::result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hlcd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .push      (push),
    .result    (push_data)
  );

  hlcd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign payload_byte   = out_data.payload_byte;
  assign payload_index  = out_data.payload_index;
  assign frame_command  = out_data.frame_command;
  assign payload_length = out_data.payload_length;
  assign last           = out_data.last;

endmodule
